// ===== hw/rtl/bfal_pkg.sv =====
// Shared constants, types and helpers for the bloom filter add/lookup block.
// No dependencies.
package bfal_pkg;

	localparam int DefMaxFilterBits = 65536;
	localparam int DefMaxKeyBytes   = 8;

	localparam int NumHashesW  = 5;
	localparam int FilterBitsW = 17;
	localparam int KeyLengthW  = 4;
	localparam int KeyW        = 64;
	localparam int ApbAddrW    = 4;
	localparam int ApbDataW    = 32;
	localparam int MixSteps    = 7;
	localparam int DivSteps    = 32;

	localparam logic [31:0] HashInit = 32'hdeadbeef;

	localparam logic [NumHashesW-1:0]  RstNumHashes  = 5'd1;
	localparam logic [FilterBitsW-1:0] RstFilterBits = 17'd65536;
	localparam logic [KeyLengthW-1:0]  RstKeyLength  = 4'd8;
	localparam logic [FilterBitsW-1:0] MinFilterBits = 17'd8;

	// register index = paddr[3:2]
	typedef enum logic [1:0] {
		REG_NUM_HASHES  = 2'd0,
		REG_FILTER_BITS = 2'd1,
		REG_KEY_LENGTH  = 2'd2,
		REG_NONE        = 2'd3
	} reg_idx_t;

	typedef enum logic [6:0] {
		ST_CLR  = 7'b0000001,
		ST_IDLE = 7'b0000010,
		ST_MIX  = 7'b0000100,
		ST_LOAD = 7'b0001000,
		ST_DIV  = 7'b0010000,
		ST_RD   = 7'b0100000,
		ST_CHK  = 7'b1000000
	} state_t;

	function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] k);
		logic [5:0] rk;
		rk = 6'd32 - {1'b0, k};
		return (x << k) | (x >> rk);
	endfunction

endpackage

// ===== hw/rtl/bloom_filter_add_lookup.sv =====
// Bloom filter add/lookup top level: APB registers, lookup3 final-mix
// sequencer, bit-serial modulo unit and byte-wide filter RAM. Uses bfal_pkg.
//
// Sequence: 7 mix rounds, a load, then per probe 32 restoring-division steps,
// a RAM read and a check/write; an empty key skips the mix rounds. One
// transaction at a time; busy stays high until done. The one-bit-per-cycle
// modulo unit sets the rate. done/found last one cycle. After arst_n the
// filter RAM is zeroed byte by byte (busy).
module bloom_filter_add_lookup #(
	parameter int MAX_FILTER_BITS = bfal_pkg::DefMaxFilterBits,
	parameter int MAX_KEY_BYTES   = bfal_pkg::DefMaxKeyBytes
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bfal_pkg::ApbAddrW-1:0] paddr,
	input  logic [bfal_pkg::ApbDataW-1:0] pwdata,
	output logic [bfal_pkg::ApbDataW-1:0] prdata,
	output logic                          pready,
	input  logic                          start,
	output logic                          busy,
	input  logic                          cmd,
	input  logic [bfal_pkg::KeyW-1:0]     key,
	output logic                          done,
	output logic                          found
);
	import bfal_pkg::*;

	localparam int StoreBytes = (MAX_FILTER_BITS + 7) / 8;
	localparam int AddrW      = (StoreBytes > 1) ? $clog2(StoreBytes) : 1;
	localparam int FbW        = $clog2(MAX_FILTER_BITS + 1);

	// configuration registers
	logic [NumHashesW-1:0]  num_hashes_q;
	logic [FilterBitsW-1:0] filter_bits_q;
	logic [KeyLengthW-1:0]  key_length_q;
	logic                   cfg_wr;
	reg_idx_t               cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_hashes_q  <= RstNumHashes;
			filter_bits_q <= RstFilterBits;
			key_length_q  <= RstKeyLength;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_NUM_HASHES:  num_hashes_q  <= pwdata[NumHashesW-1:0];
				REG_FILTER_BITS: filter_bits_q <= pwdata[FilterBitsW-1:0];
				REG_KEY_LENGTH:  key_length_q  <= pwdata[KeyLengthW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_NUM_HASHES:  prdata = ApbDataW'(num_hashes_q);
			REG_FILTER_BITS: prdata = ApbDataW'(filter_bits_q);
			REG_KEY_LENGTH:  prdata = ApbDataW'(key_length_q);
			default:         prdata = '0;
		endcase
	end

	// clamped operating values
	logic [FbW-1:0]        fb_eff;
	logic [KeyLengthW-1:0] klen;
	logic [KeyW-1:0]       kmask;

	always_comb begin
		if (32'(filter_bits_q) > 32'(MAX_FILTER_BITS)) begin
			fb_eff = FbW'(MAX_FILTER_BITS);
		end else if (filter_bits_q < MinFilterBits) begin
			fb_eff = FbW'(MinFilterBits);
		end else begin
			fb_eff = FbW'(filter_bits_q);
		end
		if (32'(key_length_q) > 32'(MAX_KEY_BYTES)) begin
			klen = KeyLengthW'(MAX_KEY_BYTES);
		end else begin
			klen = key_length_q;
		end
		for (int j = 0; j < KeyW / 8; j++) begin
			kmask[j*8 +: 8] = (KeyLengthW'(j) < klen) ? 8'hff : 8'h00;
		end
	end

	// sequencer state
	state_t                state_q;
	logic [2:0]            step_q;
	logic [4:0]            div_cnt_q;
	logic [NumHashesW-1:0] probe_q;
	logic [NumHashesW-1:0] nh_q;
	logic [FbW-1:0]        fb_q;
	logic                  cmd_q;
	logic                  present_q;
	logic                  done_q;
	logic                  found_q;
	logic [AddrW-1:0]      clr_q;
	logic [31:0]           a_q, b_q, c_q;
	logic [31:0]           hv_q, acc_q;
	logic [FbW-1:0]        rem_q;
	logic                  accept;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign done   = done_q;
	assign found  = found_q;

	// shared mix unit: dst = (dst ^ src) - rotl(src, k)
	logic [31:0] mx_x, mx_y, mx_out;
	logic [4:0]  mx_k;

	always_comb begin
		unique case (step_q)
			3'd0:    begin mx_x = c_q; mx_y = b_q; mx_k = 5'd14; end
			3'd1:    begin mx_x = a_q; mx_y = c_q; mx_k = 5'd11; end
			3'd2:    begin mx_x = b_q; mx_y = a_q; mx_k = 5'd25; end
			3'd3:    begin mx_x = c_q; mx_y = b_q; mx_k = 5'd16; end
			3'd4:    begin mx_x = a_q; mx_y = c_q; mx_k = 5'd4;  end
			3'd5:    begin mx_x = b_q; mx_y = a_q; mx_k = 5'd14; end
			default: begin mx_x = c_q; mx_y = b_q; mx_k = 5'd24; end
		endcase
		mx_out = (mx_x ^ mx_y) - rotl32(mx_y, mx_k);
	end

	// restoring division step for the probe modulo
	logic [FbW:0]   div_t;
	logic [FbW:0]   div_sub;
	logic [FbW-1:0] rem_nxt;

	always_comb begin
		div_t   = {rem_q, hv_q[31]};
		div_sub = div_t - {1'b0, fb_q};
		rem_nxt = (div_t >= {1'b0, fb_q}) ? div_sub[FbW-1:0] : div_t[FbW-1:0];
	end

	// filter RAM, one write and one registered read per cycle
	logic [7:0]       mem [StoreBytes];
	logic [7:0]       rd_q;
	logic             mem_we;
	logic [AddrW-1:0] mem_wa;
	logic [7:0]       mem_wd;
	logic [AddrW-1:0] byte_idx;
	logic [FbW-1:0]   rem_byte;
	logic [7:0]       bit_mask;

	assign rem_byte = rem_q >> 3;
	assign byte_idx = rem_byte[AddrW-1:0];
	assign bit_mask = 8'h01 << rem_q[2:0];

	always_comb begin
		mem_we = 1'b0;
		mem_wa = byte_idx;
		mem_wd = rd_q | bit_mask;
		if (state_q == ST_CLR) begin
			mem_we = 1'b1;
			mem_wa = clr_q;
			mem_wd = 8'h00;
		end else if (state_q == ST_CHK && cmd_q) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q <= mem[byte_idx];
	end

	// next probe: i=1 uses h2, i>=2 uses h1 + i*h2
	logic [31:0]           acc_nxt;
	logic [NumHashesW-1:0] probe_nxt;

	assign acc_nxt   = acc_q + b_q;
	assign probe_nxt = probe_q + NumHashesW'(1);

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLR;
			clr_q     <= '0;
			step_q    <= '0;
			div_cnt_q <= '0;
			probe_q   <= '0;
			done_q    <= 1'b0;
			found_q   <= 1'b0;
			present_q <= 1'b1;
		end else begin
			done_q  <= 1'b0;
			found_q <= 1'b0;
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + AddrW'(1);
					if (clr_q == AddrW'(StoreBytes - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						step_q    <= '0;
						probe_q   <= '0;
						present_q <= 1'b1;
						state_q   <= (klen == '0) ? ST_LOAD : ST_MIX;
					end
				end
				ST_MIX: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'(MixSteps - 1)) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					div_cnt_q <= '0;
					if (nh_q == '0) begin
						done_q  <= 1'b1;
						found_q <= !cmd_q;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + 5'd1;
					if (div_cnt_q == 5'(DivSteps - 1)) begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					probe_q   <= probe_nxt;
					div_cnt_q <= '0;
					if (probe_nxt == nh_q) begin
						done_q  <= 1'b1;
						found_q <= !cmd_q && present_q && ((rd_q & bit_mask) != 8'h00);
						state_q <= ST_IDLE;
					end else begin
						if ((rd_q & bit_mask) == 8'h00) begin
							present_q <= 1'b0;
						end
						state_q <= ST_DIV;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd_q <= cmd;
					nh_q  <= num_hashes_q;
					fb_q  <= fb_eff;
					a_q   <= HashInit + 32'(klen) + (key[31:0] & kmask[31:0]);
					b_q   <= HashInit + 32'(klen) + (key[63:32] & kmask[63:32]);
					c_q   <= HashInit + 32'(klen);
				end
			end
			ST_MIX: begin
				unique case (step_q)
					3'd1, 3'd4:  a_q <= mx_out;
					3'd2, 3'd5:  b_q <= mx_out;
					default:     c_q <= mx_out;
				endcase
			end
			ST_LOAD: begin
				hv_q  <= c_q;
				acc_q <= c_q;
				rem_q <= '0;
			end
			ST_DIV: begin
				rem_q <= rem_nxt;
				hv_q  <= {hv_q[30:0], 1'b0};
			end
			ST_CHK: begin
				acc_q <= acc_nxt;
				hv_q  <= (probe_nxt == NumHashesW'(1)) ? b_q : acc_nxt;
				rem_q <= '0;
			end
			default: ;
		endcase
	end

	// checks
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("done without a transaction in flight");
	a_add_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		(done && cmd_q) |-> !found)
		else $error("add reported found");
	a_found_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		found |-> done)
		else $error("found outside done strobe");
	a_ram_write_ctx: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_CLR || (state_q == ST_CHK && cmd_q)))
		else $error("filter RAM written outside clear or add");

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for bloom_filter_add_lookup: APB register setup,
// queued add/lookup stimulus, in-bench lookup3 Bloom predictor. Uses bfal_pkg.
module tb;
	import bfal_pkg::*;

	typedef enum logic {
		OP_LOOKUP = 1'b0,
		OP_ADD    = 1'b1
	} op_t;

	typedef struct {
		op_t         op;
		logic [63:0] key;
	} bloom_req_t;

	localparam int CycleLimit = 2000000;
	localparam int FilterSize = 65536;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ApbAddrW-1:0] paddr;
	logic [ApbDataW-1:0] pwdata;
	logic [ApbDataW-1:0] prdata;
	logic                pready;
	logic                start;
	logic                busy;
	logic                cmd;
	logic [KeyW-1:0]     key;
	logic                done;
	logic                found;

	// pending requests, expected found bits, recently added keys
	bloom_req_t  req_q[$];
	logic        found_q[$];
	logic [63:0] added_keys[$];

	// predictor state
	logic        bit_store [FilterSize];
	logic [4:0]  cur_hashes;
	logic [16:0] cur_fbits;
	logic [3:0]  cur_klen;

	int  errors, n_adds, n_lookups, n_hits, cycles;
	int  gap;
	bit  hold, no_idle, accepted;

	bloom_filter_add_lookup i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.start   (start),
		.busy    (busy),
		.cmd     (cmd),
		.key     (key),
		.done    (done),
		.found   (found)
	);

	always #4 clk = ~clk;

	function automatic logic [31:0] rot_left(input logic [31:0] x, input int k);
		return (x << k) | (x >> (32 - k));
	endfunction

	// lookup3 tail step and final mix for keys of up to 8 bytes
	function automatic void lookup3_hash(input logic [63:0] k_in, input int len,
			output logic [31:0] h1, output logic [31:0] h2);
		logic [31:0] a, b, c;
		logic [63:0] k;
		k = k_in;
		if (len < 8)
			k = k & ((64'd1 << (len * 8)) - 64'd1);
		a = 32'hdeadbeef + len;
		b = a;
		c = a;
		if (len == 0) begin
			h1 = c;
			h2 = b;
			return;
		end
		a = a + k[31:0];
		b = b + k[63:32];
		c = c ^ b; c = c - rot_left(b, 14);
		a = a ^ c; a = a - rot_left(c, 11);
		b = b ^ a; b = b - rot_left(a, 25);
		c = c ^ b; c = c - rot_left(b, 16);
		a = a ^ c; a = a - rot_left(c, 4);
		b = b ^ a; b = b - rot_left(a, 14);
		c = c ^ b; c = c - rot_left(b, 24);
		h1 = c;
		h2 = b;
	endfunction

	// probe the filter model, update on add, return found
	function automatic logic bloom_probe(input op_t op, input logic [63:0] k);
		logic [31:0] h1, h2, h, fb;
		int          len;
		logic        present;
		fb = cur_fbits;
		if (fb < 8)
			fb = 8;
		if (fb > FilterSize)
			fb = FilterSize;
		len = (cur_klen > 8) ? 8 : cur_klen;
		lookup3_hash(k, len, h1, h2);
		present = 1'b1;
		for (int i = 0; i < cur_hashes; i++) begin
			if (i == 0)
				h = h1;
			else if (i == 1)
				h = h2;
			else
				h = h1 + i * h2;
			h = h % fb;
			if (op == OP_ADD)
				bit_store[h[15:0]] = 1'b1;
			else if (!bit_store[h[15:0]])
				present = 1'b0;
		end
		return (op == OP_LOOKUP) && present;
	endfunction

	task automatic report(input string what, input logic got, input logic want);
		errors++;
		$display("mismatch at cycle %0d: %s got %0b want %0b", cycles, what, got, want);
	endtask

	// request driver: inputs change on the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (start && !accepted) begin
			start <= 1'b1;
		end else if (gap > 0) begin
			gap--;
			start <= 1'b0;
		end else if (hold || req_q.size() == 0) begin
			start <= 1'b0;
		end else if (!no_idle && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(0, 2);
			start <= 1'b0;
		end else begin
			start <= 1'b1;
			cmd   <= req_q[0].op;
			key   <= req_q[0].key;
		end
	end

	// monitor: accept transactions, predict, check results
	always @(posedge clk) begin
		logic want;
		cycles++;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles", cycles);
			$display("tb: FAIL");
			$finish;
		end else if (arst_n) begin
			accepted <= start && !busy;
			if (start && !busy) begin
				want = bloom_probe(op_t'(cmd), key);
				found_q.push_back(want);
				void'(req_q.pop_front());
				if (cmd == OP_ADD)
					n_adds++;
				else
					n_lookups++;
			end
			if (done) begin
				if (found_q.size() == 0) begin
					report("unexpected transaction", found, 1'b0);
				end else begin
					want = found_q.pop_front();
					if (found !== want)
						report("found", found, want);
					if (want)
						n_hits++;
				end
			end
		end
	end

	task automatic apb_write(input reg_idx_t idx, input logic [31:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_NUM_HASHES:  cur_hashes = value[4:0];
			REG_FILTER_BITS: cur_fbits  = value[16:0];
			REG_KEY_LENGTH:  cur_klen   = value[3:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		while (req_q.size() != 0 || found_q.size() != 0 || start || busy)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic push_req(input op_t op, input logic [63:0] k);
		bloom_req_t r;
		r.op  = op;
		r.key = k;
		req_q.push_back(r);
		if (op == OP_ADD) begin
			added_keys.push_back(k);
			if (added_keys.size() > 64)
				void'(added_keys.pop_front());
		end
	endtask

	// mostly add-then-lookup traffic; unused key bytes get noise
	task automatic run_phase(input logic [31:0] nh, input logic [31:0] fb,
			input logic [31:0] kl, input int n);
		logic [63:0] k;
		int          sel, klen;
		drain();
		apb_write(REG_NUM_HASHES, nh);
		apb_write(REG_FILTER_BITS, fb);
		apb_write(REG_KEY_LENGTH, kl);
		klen = (cur_klen > 8) ? 8 : cur_klen;
		for (int i = 0; i < n; i++) begin
			k = {$urandom, $urandom};
			sel = $urandom_range(0, 9);
			if (sel < 4) begin
				push_req(OP_ADD, k);
			end else if (sel < 8 && added_keys.size() > 0) begin
				k = added_keys[$urandom_range(0, added_keys.size() - 1)]
					^ (($urandom_range(0, 1) && klen < 8) ? (k << (klen * 8)) : 64'd0);
				push_req(OP_LOOKUP, k);
			end else begin
				push_req(OP_LOOKUP, k);
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		start = 1'b0;
		cmd = 1'b0;
		key = '0;
		gap = 0;
		hold = 1'b0;
		no_idle = 1'b0;
		accepted = 1'b0;
		foreach (bit_store[i])
			bit_store[i] = 1'b0;
		cur_hashes = RstNumHashes;
		cur_fbits  = RstFilterBits;
		cur_klen   = RstKeyLength;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset settings, key extremes, add then lookup
		push_req(OP_LOOKUP, 64'd0);
		push_req(OP_ADD, 64'd0);
		push_req(OP_LOOKUP, 64'd0);
		push_req(OP_LOOKUP, '1);
		push_req(OP_ADD, '1);
		push_req(OP_LOOKUP, '1);
		push_req(OP_ADD, 64'haaaa_aaaa_aaaa_aaaa);
		push_req(OP_LOOKUP, 64'h5555_5555_5555_5555);
		push_req(OP_ADD, 64'h5555_5555_5555_5555);
		push_req(OP_LOOKUP, 64'h5555_5555_5555_5555);
		push_req(OP_LOOKUP, 64'h8000_0000_0000_0001);
		push_req(OP_ADD, 64'h0000_0000_0000_0001);
		push_req(OP_LOOKUP, 64'h0000_0000_0000_0001);

		// explicit pause until all results are back, then a write to no register
		drain();
		hold = 1'b1;
		apb_write(REG_NONE, '1);
		hold = 1'b0;

		run_phase(1, 65536, 8, 200);
		run_phase(0, 100, 3, 40);              // no probes
		run_phase(16, 0, 1, 100);              // tiny filter, clamped up
		run_phase(31, 32'hffff_ffff, 15, 20);  // many probes, clamped filter and key
		run_phase(2, 7, 0, 60);                // empty key
		run_phase(4, 1000, 5, 300);
		run_phase(3, 65535, 8, 300);
		run_phase(7, 4096, 2, 200);
		run_phase(1, 256, 4, 200);
		no_idle = 1'b1;
		run_phase(5, 2000, 7, 230);
		drain();

		$display("covered %0d adds and %0d lookups (%0d present) over 11 settings",
			n_adds, n_lookups, n_hits);
		$display("probe counts 0..31, filter sizes 8..65536, key lengths 0..15");
		if (errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
